>>> hdl/q2e_pkg.sv
// Shared constants, tables and types for the quaternion to Euler angle converter.
// No dependencies; imported by q2e_isqrt, q2e_cordic and quaternion_to_euler_angles.
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

  // Vectoring steps per arctangent, 8 to 24
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  // Pipeline depth of one arctangent unit: sign fix, two normalize stages, steps, round
  localparam int CORDIC_LAT   = CORDIC_STEPS + 4;

  // Square root of a 64-bit radicand, one result bit per stage
  localparam int ISQRT_STEPS  = 32;
  localparam int ROOT_W       = ISQRT_STEPS;
  localparam int RAD_W        = 2 * ISQRT_STEPS;
  localparam int REM_W        = ISQRT_STEPS + 3;

  // Datapath widths
  localparam int OPW = 34;   // atan2 operands, magnitude up to 2^32
  localparam int NW  = 33;   // squared norm
  localparam int XW  = 45;   // CORDIC x/y after normalization and gain
  localparam int ZW  = 33;   // angle accumulator, Q29 radians
  localparam int MW  = 41;   // normalized magnitude lies in [2^40, 2^41)
  localparam int ANG_W   = 16;
  localparam int PITCH_W = 15;

  localparam logic signed [ANG_W-1:0] OUT_PI      = 16'sd25736;
  localparam logic signed [ANG_W-1:0] OUT_HALF_PI = 16'sd12868;
  localparam logic signed [ZW-1:0]    PI_Q29      = 33'sd1686629713;

  // atan(2^-i) in Q29 radians
  localparam logic signed [ZW-1:0] ATAN_Q29 [ATAN_LEN] = '{
    33'sd421657428, 33'sd248918915, 33'sd131521918, 33'sd66762579,
    33'sd33510843,  33'sd16771758,  33'sd8387925,   33'sd4194219,
    33'sd2097141,   33'sd1048575,   33'sd524288,    33'sd262144,
    33'sd131072,    33'sd65536,     33'sd32768,     33'sd16384,
    33'sd8192,      33'sd4096,      33'sd2048,      33'sd1024,
    33'sd512,       33'sd256,       33'sd128,       33'sd64
  };

  // One CORDIC stage's working set
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [MW-1:0]        m;
    logic                 zero;
  } cs_t;

  // Flags that ride alongside the pitch path
  typedef struct packed {
    logic deg;
    logic ge;
    logic le;
  } flag_t;

  // One result item
  typedef struct packed {
    logic                      deg;
    logic signed [ANG_W-1:0]   yaw;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [ANG_W-1:0]   roll;
  } res_t;

endpackage
`default_nettype wire

>>> hdl/quaternion_to_euler_angles.sv
// Top level: quaternion (Q2.14) to ZYX Euler angles (Q2.13 radians) with stream ports.
// Depends on q2e_pkg, q2e_isqrt and q2e_cordic.
//
//   port group | dir | tdata bits (low to high)             | tuser
//   s_axis     | in  | quat_w, quat_x, quat_y, quat_z       | -
//   m_axis     | out | roll_angle, pitch_angle, yaw_angle, 0 | degenerate
//
// One request is taken every cycle while s_axis_tready is high; the pipeline depth is set
// by the 32-stage square root feeding the pitch CORDIC.
// Reset clears only valid bits and the output/skid control; no clearing pass is needed.
// A stalled output holds in the output register; one more result lands in the skid
// register, then s_axis_tready drops and the whole pipeline freezes without loss.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
  output logic        m_axis_tuser    // degenerate
);
  import q2e_pkg::*;

  localparam int TOTAL    = ISQRT_STEPS + CORDIC_LAT + 5;
  localparam int A_LAG    = ISQRT_STEPS + 2;
  localparam int FLAG_LAG = ISQRT_STEPS + 2 + CORDIC_LAT;
  localparam int YR_LAG   = ISQRT_STEPS + 3;

  logic en;
  logic [TOTAL-1:0] valid_q;

  // Stage 1: all products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, wz_q, xy_q, wx_q, yz_q, wy_q, zx_q;
  logic               deg1_q;

  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q   <= qw * qw;
      xx_q   <= qx * qx;
      yy_q   <= qy * qy;
      zz_q   <= qz * qz;
      wz_q   <= qw * qz;
      xy_q   <= qx * qy;
      wx_q   <= qw * qx;
      yz_q   <= qy * qz;
      wy_q   <= qw * qy;
      zx_q   <= qz * qx;
      deg1_q <= (s_axis_tdata == '0);
    end
  end

  // Stage 2: norm and atan2 operands
  logic signed [35:0]    n2_f, yaw_y_f, yaw_x_f, roll_y_f, roll_x_f, a_f;
  logic [NW-1:0]         n2_q;
  logic signed [OPW-1:0] yaw_y_q, yaw_x_q, roll_y_q, roll_x_q, a2_q;
  logic                  deg2_q;

  always_comb begin
    n2_f     = 36'(ww_q) + 36'(xx_q) + 36'(yy_q) + 36'(zz_q);
    yaw_y_f  = (36'(wz_q) + 36'(xy_q)) <<< 1;
    yaw_x_f  = n2_f - ((36'(yy_q) + 36'(zz_q)) <<< 1);
    roll_y_f = (36'(wx_q) + 36'(yz_q)) <<< 1;
    roll_x_f = n2_f - ((36'(xx_q) + 36'(yy_q)) <<< 1);
    a_f      = (36'(wy_q) - 36'(zx_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q     <= n2_f[NW-1:0];
      yaw_y_q  <= yaw_y_f[OPW-1:0];
      yaw_x_q  <= yaw_x_f[OPW-1:0];
      roll_y_q <= roll_y_f[OPW-1:0];
      roll_x_q <= roll_x_f[OPW-1:0];
      a2_q     <= a_f[OPW-1:0];
      deg2_q   <= deg1_q;
    end
  end

  // Stage 3: pitch range checks and the factors of n2^2 - a^2
  logic signed [OPW-1:0] n2_s, am_s;
  logic [NW-1:0]         u_q;
  logic [NW:0]           v_q;
  flag_t                 flag3_q;
  logic signed [OPW-1:0] a3_q;

  assign n2_s = OPW'(n2_q);
  assign am_s = (a2_q < 0) ? -a2_q : a2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q         <= NW'(n2_s - am_s);
      v_q         <= (NW+1)'(n2_s + am_s);
      flag3_q.deg <= deg2_q;
      flag3_q.ge  <= (a2_q >= n2_s);
      flag3_q.le  <= (a2_q <= -n2_s);
      a3_q        <= a2_q;
    end
  end

  // Stage 4: two partial products; stage 5: radicand
  logic [NW+16:0]    plo_q, phi_q;
  logic [RAD_W-1:0]  rad_q;
  logic [RAD_W+2:0]  rad_f;

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_q <= u_q * v_q[16:0];
      phi_q <= u_q * v_q[NW:17];
    end
  end

  assign rad_f = (RAD_W+3)'(plo_q) + ((RAD_W+3)'(phi_q) << 17);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= rad_f[RAD_W-1:0];
    end
  end

  logic [ROOT_W-1:0] root;

  q2e_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // Side delay lines
  logic signed [OPW-1:0]   a_dly    [A_LAG];
  flag_t                   flag_dly [FLAG_LAG];
  logic signed [ANG_W-1:0] yaw_dly  [YR_LAG];
  logic signed [ANG_W-1:0] roll_dly [YR_LAG];
  logic signed [ANG_W-1:0] yaw_c, roll_c, pitch_c;

  q2e_cordic u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (yaw_y_q),
    .x_i     (yaw_x_q),
    .angle_o (yaw_c)
  );

  q2e_cordic u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (roll_y_q),
    .x_i     (roll_x_q),
    .angle_o (roll_c)
  );

  q2e_cordic u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (a_dly[A_LAG-1]),
    .x_i     (OPW'(root)),
    .angle_o (pitch_c)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dly[0]    <= a3_q;
      flag_dly[0] <= flag3_q;
      yaw_dly[0]  <= yaw_c;
      roll_dly[0] <= roll_c;
      for (int k = 1; k < A_LAG; k++) begin
        a_dly[k] <= a_dly[k-1];
      end
      for (int k = 1; k < FLAG_LAG; k++) begin
        flag_dly[k] <= flag_dly[k-1];
      end
      for (int k = 1; k < YR_LAG; k++) begin
        yaw_dly[k]  <= yaw_dly[k-1];
        roll_dly[k] <= roll_dly[k-1];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[TOTAL-2:0], s_axis_tvalid};
    end
  end

  // Final select: degenerate and pitch overrides
  res_t  res_last;
  flag_t fl;
  logic signed [ANG_W-1:0] pitch_sel;

  assign fl = flag_dly[FLAG_LAG-1];

  always_comb begin
    if (fl.ge) begin
      pitch_sel = OUT_HALF_PI;
    end else if (fl.le) begin
      pitch_sel = -OUT_HALF_PI;
    end else if (pitch_c > OUT_HALF_PI) begin
      pitch_sel = OUT_HALF_PI;
    end else if (pitch_c < -OUT_HALF_PI) begin
      pitch_sel = -OUT_HALF_PI;
    end else begin
      pitch_sel = pitch_c;
    end
    res_last.deg   = fl.deg;
    res_last.roll  = roll_dly[YR_LAG-1];
    res_last.pitch = pitch_sel[PITCH_W-1:0];
    res_last.yaw   = yaw_dly[YR_LAG-1];
    if (fl.deg) begin
      res_last.roll  = '0;
      res_last.pitch = '0;
      res_last.yaw   = '0;
    end
  end

  // Output register plus skid register
  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= valid_q[TOTAL-1];
      end else begin
        out_valid_q <= valid_q[TOTAL-1];
      end
    end else if (m_axis_tready) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_q <= res_last;
      end else begin
        out_q <= res_last;
      end
    end else if (m_axis_tready) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.yaw, out_q.pitch, out_q.roll};
  assign m_axis_tuser  = out_q.deg;

endmodule
`default_nettype wire

>>> hdl/q2e_isqrt.sv
// Pipelined integer square root, floor(sqrt(rad_i)), one root bit per stage.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_isqrt (
  input  wire                       clk_i,
  input  wire                       en_i,
  input  wire [q2e_pkg::RAD_W-1:0]  rad_i,
  output logic [q2e_pkg::ROOT_W-1:0] root_o
);
  import q2e_pkg::*;

  logic [REM_W-1:0]  rem_q  [ISQRT_STEPS];
  logic [ROOT_W-1:0] root_q [ISQRT_STEPS];
  logic [RAD_W-1:0]  rad_q  [ISQRT_STEPS];

  for (genvar g = 0; g < ISQRT_STEPS; g++) begin : g_step
    logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_d;
    logic [ROOT_W-1:0] root_in, root_d;
    logic [RAD_W-1:0]  rad_in;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_rest
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
    end

    // bring down the next two radicand bits and try the new root bit
    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1-2*g -: 2]};
      trial  = REM_W'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        rad_q[g]  <= rad_in;
      end
    end
  end

  assign root_o = root_q[ISQRT_STEPS-1];

endmodule
`default_nettype wire

>>> hdl/q2e_cordic.sv
// Pipelined vectoring CORDIC: atan2(y_i, x_i) in Q2.13 radians, clamped to +-pi.
// Every stage advances only on en_i. Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic (
  input  wire                             clk_i,
  input  wire                             en_i,
  input  wire signed [q2e_pkg::OPW-1:0]   y_i,
  input  wire signed [q2e_pkg::OPW-1:0]   x_i,
  output logic signed [q2e_pkg::ANG_W-1:0] angle_o
);
  import q2e_pkg::*;

  cs_t pre_q, n1_q, n2_q, pre_d, n1_d, n2_d;
  cs_t it_q [CORDIC_STEPS];
  logic signed [ANG_W-1:0] angle_q;
  logic signed [ANG_W-1:0] angle_d;

  // Fold the left half plane onto the right, starting from +-pi
  always_comb begin
    pre_d      = '0;
    pre_d.zero = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      pre_d.z = (y_i >= 0) ? PI_Q29 : -PI_Q29;
      pre_d.x = XW'(-x_i);
      pre_d.y = XW'(-y_i);
    end else begin
      pre_d.z = '0;
      pre_d.x = XW'(x_i);
      pre_d.y = XW'(y_i);
    end
  end

  // Normalize, coarse shifts 32/16/8
  always_comb begin
    logic signed [XW-1:0] my;
    logic [XW-1:0]        mx;
    int                   sh;
    n1_d = pre_q;
    my   = (pre_q.y < 0) ? -pre_q.y : pre_q.y;
    mx   = (pre_q.x > my) ? pre_q.x : my;
    n1_d.m = mx[MW-1:0];
    for (int j = 0; j < 3; j++) begin
      sh = 32 >> j;
      if ((n1_d.m >> (MW - sh)) == '0) begin
        n1_d.m = n1_d.m << sh;
        n1_d.x = n1_d.x <<< sh;
        n1_d.y = n1_d.y <<< sh;
      end
    end
  end

  // Normalize, fine shifts 4/2/1
  always_comb begin
    int sh;
    n2_d = n1_q;
    for (int j = 0; j < 3; j++) begin
      sh = 4 >> j;
      if ((n2_d.m >> (MW - sh)) == '0) begin
        n2_d.m = n2_d.m << sh;
        n2_d.x = n2_d.x <<< sh;
        n2_d.y = n2_d.y <<< sh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
      n1_q  <= n1_d;
      n2_q  <= n2_d;
    end
  end

  // Rotation steps, one per stage; a zero y holds the vector
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_it
    cs_t                  in_s, out_s;
    logic signed [XW-1:0] xi, yi;

    if (g == 0) begin : g_first
      assign in_s = n2_q;
    end else begin : g_rest
      assign in_s = it_q[g-1];
    end

    assign xi = in_s.x;
    assign yi = in_s.y;

    always_comb begin
      out_s = in_s;
      if (yi > 0) begin
        out_s.x = xi + (yi >>> g);
        out_s.y = yi - (xi >>> g);
        out_s.z = in_s.z + ATAN_Q29[g];
      end else if (yi < 0) begin
        out_s.x = xi - (yi >>> g);
        out_s.y = yi + (xi >>> g);
        out_s.z = in_s.z - ATAN_Q29[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[g] <= out_s;
      end
    end
  end

  // Round Q29 to Q13 half up and clamp to +-pi
  always_comb begin
    logic signed [ZW-1:0]    zr;
    logic signed [ZW-17:0]   r;
    logic signed [ANG_W-1:0] a_d;
    zr = it_q[CORDIC_STEPS-1].z + ZW'(32768);
    r  = zr[ZW-1:16];
    if (r > ($bits(r))'(OUT_PI)) begin
      a_d = OUT_PI;
    end else if (r < -($bits(r))'(OUT_PI)) begin
      a_d = -OUT_PI;
    end else begin
      a_d = r[ANG_W-1:0];
    end
    if (it_q[CORDIC_STEPS-1].zero) begin
      a_d = '0;
    end
    angle_d = a_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule
`default_nettype wire
